### rtl/core/ipvrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipvrr_pkg;

  localparam int WAYS_DEF = 16;
  localparam int SETS_DEF = 64;

  localparam int ACTION_W  = 2;
  localparam int SET_IDX_W = 6;
  localparam int WAY_IDX_W = 4;
  localparam int POS_W     = 5;
  localparam int VEC_W     = 64;
  localparam int INS_W     = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int SET_CODES  = 1 << SET_IDX_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_HIT    = 2'd1,
    ACT_VICTIM = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic {
    CFG_PROMOTE_VECTOR  = 1'b0,
    CFG_INSERT_POSITION = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } back_state_t;

  // decoded request as it travels through the queue
  typedef struct packed {
    action_t               action;
    logic [WAY_IDX_W-1:0]  way;
    logic                  way_ok;
  } req_t;

endpackage

`default_nettype wire

### rtl/core/ipvrr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ipvrr_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/ipvrr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ipvrr_front #(
  parameter int WAYS = ipvrr_pkg::WAYS_DEF,
  parameter int SETS = ipvrr_pkg::SETS_DEF,
  localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ipvrr_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                               init_done,
  output logic                                    q_valid,
  output ipvrr_pkg::req_t                         q_req,
  output logic      [SW-1:0]                      q_row,
  input  wire logic                               q_pop
);

  localparam int WAY_CMP_W = ipvrr_pkg::POS_W;

  logic [SW-1:0]                     set_lut [ipvrr_pkg::SET_CODES];
  logic [ipvrr_pkg::ACTION_W-1:0]    in_action;
  logic [ipvrr_pkg::SET_IDX_W-1:0]   in_set;
  logic [ipvrr_pkg::WAY_IDX_W-1:0]   in_way;
  ipvrr_pkg::req_t                   dec_req;
  logic [SW-1:0]                     dec_row;
  logic                              push;

  ipvrr_pkg::req_t ent_req_r [2];
  logic [SW-1:0]   ent_row_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;

  // set index folded onto the implemented sets
  for (genvar i = 0; i < ipvrr_pkg::SET_CODES; i++) begin : g_set_lut
    assign set_lut[i] = SW'(i % SETS);
  end

  assign in_action = in_tdata[1:0];
  assign in_set    = in_tdata[7:2];
  assign in_way    = in_tdata[11:8];

  always_comb begin
    dec_req.action = ipvrr_pkg::action_t'(in_action);
    dec_req.way    = in_way;
    dec_req.way_ok = (WAY_CMP_W'(in_way) < WAY_CMP_W'(WAYS));
    dec_row        = set_lut[in_set];
  end

  assign in_tready = init_done && (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_req_r[wr_ptr_r] <= dec_req;
      ent_row_r[wr_ptr_r] <= dec_row;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = ent_req_r[rd_ptr_r];
  assign q_row   = ent_row_r[rd_ptr_r];

endmodule

`default_nettype wire

### rtl/core/ipvrr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ipvrr_back #(
  parameter int WAYS = ipvrr_pkg::WAYS_DEF,
  parameter int SETS = ipvrr_pkg::SETS_DEF,
  localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [ipvrr_pkg::VEC_W-1:0]       cfg_wdata,
  input  wire logic                              q_valid,
  input  ipvrr_pkg::req_t                        q_req,
  input  wire logic [SW-1:0]                     q_row,
  output logic                                   q_pop,
  output logic                                   init_done,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [ipvrr_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int PW    = $clog2(WAYS + 1);
  localparam int WIW   = $clog2(WAYS);
  localparam int NP    = 1 << WIW;
  localparam int RW    = WAYS * PW;
  localparam int EW    = ipvrr_pkg::POS_W;
  localparam logic [EW-1:0] WAYS_E = EW'(WAYS);
  localparam logic [EW-1:0] LAST_E = EW'(WAYS - 1);

  ipvrr_pkg::back_state_t state_r, state_nxt;
  logic [SW-1:0]                       clr_cnt_r;
  ipvrr_pkg::req_t                     req_r;
  logic [SW-1:0]                       row_r;
  logic                                out_valid_r;
  logic [ipvrr_pkg::WAY_IDX_W-1:0]     out_way_r;
  logic [EW-1:0]                       out_pos_r;
  logic [ipvrr_pkg::VEC_W-1:0]         promote_vector_r;
  logic [ipvrr_pkg::INS_W-1:0]         insert_position_r;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [RW-1:0] ram_rdata;
  logic [RW-1:0] clr_row;
  logic [RW-1:0] new_row;
  logic          row_write;
  logic          exec_done;

  logic [EW-1:0]  pos_cur [WAYS];
  logic [EW-1:0]  pos_new [WAYS];
  logic [WIW-1:0] way_sel;
  logic [EW-1:0]  ins_c;
  logic [EW-1:0]  old_pos;
  logic [3:0]     vec_ent;
  logic [EW-1:0]  new_pos;
  logic [EW-1:0]  tp [WIW+1][NP];
  logic [ipvrr_pkg::WAY_IDX_W-1:0] tw [WIW+1][NP];
  logic [ipvrr_pkg::WAY_IDX_W-1:0] res_way;
  logic [EW-1:0]  res_pos;

  ipvrr_ram #(
    .WIDTH (RW),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_row),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w*PW +: PW] = PW'(WAYS);
    end
  end

  // row update and victim search on the row just read
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      pos_cur[w] = EW'(ram_rdata[w*PW +: PW]);
    end
    way_sel = req_r.way[WIW-1:0];
    ins_c   = (EW'(insert_position_r) >= WAYS_E) ? LAST_E : EW'(insert_position_r);
    old_pos = pos_cur[way_sel];
    vec_ent = promote_vector_r[{old_pos[3:0], 2'b00} +: 4];
    new_pos = (EW'(vec_ent) >= WAYS_E) ? LAST_E : EW'(vec_ent);
    row_write = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      pos_new[w] = pos_cur[w];
    end
    if (req_r.way_ok && req_r.action == ipvrr_pkg::ACT_INSERT) begin
      row_write = 1'b1;
      for (int w = 0; w < WAYS; w++) begin
        if (pos_cur[w] >= ins_c && pos_cur[w] < WAYS_E) begin
          pos_new[w] = pos_cur[w] + 1'b1;
        end
      end
      pos_new[way_sel] = ins_c;
    end else if (req_r.way_ok && req_r.action == ipvrr_pkg::ACT_HIT &&
                 old_pos < WAYS_E) begin
      row_write = 1'b1;
      for (int w = 0; w < WAYS; w++) begin
        if (new_pos < old_pos && pos_cur[w] >= new_pos && pos_cur[w] < old_pos) begin
          pos_new[w] = pos_cur[w] + 1'b1;
        end else if (new_pos > old_pos && pos_cur[w] > old_pos &&
                     pos_cur[w] <= new_pos) begin
          pos_new[w] = pos_cur[w] - 1'b1;
        end
      end
      pos_new[way_sel] = new_pos;
    end
    for (int w = 0; w < WAYS; w++) begin
      new_row[w*PW +: PW] = PW'(pos_new[w]);
    end
  end

  // pairwise max tree, the lower way keeps a tie
  always_comb begin
    for (int l = 0; l <= WIW; l++) begin
      for (int i = 0; i < NP; i++) begin
        tp[l][i] = '0;
        tw[l][i] = '0;
      end
    end
    for (int i = 0; i < NP; i++) begin
      tp[0][i] = (i < WAYS) ? pos_cur[i] : '0;
      tw[0][i] = ipvrr_pkg::WAY_IDX_W'(i);
    end
    for (int l = 0; l < WIW; l++) begin
      for (int i = 0; i < (NP >> (l + 1)); i++) begin
        if (tp[l][2*i+1] > tp[l][2*i]) begin
          tp[l+1][i] = tp[l][2*i+1];
          tw[l+1][i] = tw[l][2*i+1];
        end else begin
          tp[l+1][i] = tp[l][2*i];
          tw[l+1][i] = tw[l][2*i];
        end
      end
    end
    if (req_r.action == ipvrr_pkg::ACT_VICTIM) begin
      res_way = tw[WIW][0];
      res_pos = tp[WIW][0];
    end else begin
      res_way = '0;
      res_pos = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipvrr_pkg::ST_CLEAR: begin
        if (clr_cnt_r == SW'(SETS - 1)) begin
          state_nxt = ipvrr_pkg::ST_IDLE;
        end
      end
      ipvrr_pkg::ST_IDLE: begin
        if (q_valid && (!out_valid_r || out_tready)) begin
          state_nxt = ipvrr_pkg::ST_EXEC;
        end
      end
      ipvrr_pkg::ST_EXEC: state_nxt = ipvrr_pkg::ST_IDLE;
      default:            state_nxt = ipvrr_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = row_r;
    ram_wdata = new_row;
    exec_done = 1'b0;
    case (state_r)
      ipvrr_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = clr_row;
      end
      ipvrr_pkg::ST_IDLE: begin
        q_pop  = q_valid && (!out_valid_r || out_tready);
        ram_re = q_pop;
      end
      ipvrr_pkg::ST_EXEC: begin
        ram_we    = row_write;
        exec_done = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ipvrr_pkg::ST_CLEAR;
      clr_cnt_r         <= '0;
      out_valid_r       <= 1'b0;
      promote_vector_r  <= '0;
      insert_position_r <= 4'd15;
    end else begin
      state_r <= state_nxt;
      if (state_r == ipvrr_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (exec_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (ipvrr_pkg::cfg_reg_t'(cfg_index))
          ipvrr_pkg::CFG_PROMOTE_VECTOR:  promote_vector_r  <= cfg_wdata;
          ipvrr_pkg::CFG_INSERT_POSITION: insert_position_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r <= q_req;
      row_r <= q_row;
    end
    if (exec_done) begin
      out_way_r <= res_way;
      out_pos_r <= res_pos;
    end
  end

  assign init_done  = (state_r != ipvrr_pkg::ST_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(ipvrr_pkg::OUT_DATA_W - ipvrr_pkg::WAY_IDX_W - EW)'(0),
                       out_pos_r, out_way_r};

  a_pop_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ipvrr_pkg::ST_EXEC && !out_valid_r))
    else $error("pop not followed by execute with a free output slot");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ipvrr_pkg::ST_CLEAR) |-> (!q_pop && !out_valid_r))
    else $error("activity during clearing pass");

  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ipvrr_pkg::ST_EXEC))
    else $error("result appeared without execute cycle");

  a_victim_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pos_r <= WAYS_E))
    else $error("victim position out of range");

endmodule

`default_nettype wire

### rtl/core/ipv_recency_replacement_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  ports                          payload
// -------  -----------------------------  -----------------------------------------
// in       in_tvalid/in_tready/in_tdata   action[1:0] set_index[7:2] way_index[11:8]
// out      out_tvalid/out_tready/out_tdata victim_way[3:0] victim_position[8:4]
// cfg      cfg_valid/cfg_ready/cfg_index  0 promote_vector, 1 insert_position
//
// in the back end each item passes the registered row read (ST_IDLE), then the update,
// row write-back and result load (ST_EXEC); the read-modify-write of one row, which
// the next item may read again, keeps a new item out until the last is written back.
// after reset a clearing pass writes every set empty, with in_tready low.
// a two-entry queue sits between the input and the back end; the output register
// lets the next row read start in the same cycle a result is taken.

module ipv_recency_replacement_top #(
  parameter int WAYS = ipvrr_pkg::WAYS_DEF,
  parameter int SETS = ipvrr_pkg::SETS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // action[1:0], set_index[7:2], way_index[11:8], zero pad
  input  wire logic [ipvrr_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // victim_way[3:0], victim_position[8:4], zero pad
  output logic      [ipvrr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [ipvrr_pkg::VEC_W-1:0]       cfg_wdata
);

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;

  logic            init_done;
  logic            q_valid;
  ipvrr_pkg::req_t q_req;
  logic [SW-1:0]   q_row;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  ipvrr_front #(
    .WAYS (WAYS),
    .SETS (SETS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .init_done (init_done),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_row     (q_row),
    .q_pop     (q_pop)
  );

  ipvrr_back #(
    .WAYS (WAYS),
    .SETS (SETS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_row      (q_row),
    .q_pop      (q_pop),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### dv/ipv_recency_replacement_top_tb.sv
`timescale 1ns / 1ps

module ipv_recency_replacement_top_tb;

  localparam int WAYS = ipvrr_pkg::WAYS_DEF;
  localparam int SETS = ipvrr_pkg::SETS_DEF;

  typedef struct {
    ipvrr_pkg::action_t              act;
    logic [ipvrr_pkg::SET_IDX_W-1:0] set;
    logic [ipvrr_pkg::WAY_IDX_W-1:0] way;
  } request_t;

  typedef struct {
    logic [ipvrr_pkg::WAY_IDX_W-1:0] way;
    logic [ipvrr_pkg::POS_W-1:0]     pos;
  } victim_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [ipvrr_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [ipvrr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic                             cfg_index = 1'b0;
  logic [ipvrr_pkg::VEC_W-1:0]      cfg_wdata = '0;

  ipv_recency_replacement_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [ipvrr_pkg::POS_W-1:0] recency [SETS*WAYS];
  logic [ipvrr_pkg::VEC_W-1:0] promote_vec = '0;
  logic [ipvrr_pkg::INS_W-1:0] insert_pos = 4'd15;

  request_t    pending_reqs[$];
  victim_t     expected_victims[$];
  int unsigned mismatches = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  logic        in_acc = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  logic [3:0]  focus_hi = '0;

  initial begin
    foreach (recency[i]) recency[i] = ipvrr_pkg::POS_W'(WAYS);
  end

  function automatic int unsigned draw_gap(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic update_recency(input ipvrr_pkg::action_t act,
                                input logic [ipvrr_pkg::SET_IDX_W-1:0] set,
                                input logic [ipvrr_pkg::WAY_IDX_W-1:0] way,
                                output victim_t res);
    int base, w, p, ins, old, tgt;
    base = int'(set % SETS) * WAYS;
    res.way = '0;
    res.pos = '0;
    case (act)
      ipvrr_pkg::ACT_INSERT: begin
        if (way < WAYS) begin
          ins = (insert_pos >= WAYS) ? WAYS - 1 : int'(insert_pos);
          for (w = 0; w < WAYS; w++) begin
            p = recency[base+w];
            if (p >= ins && p < WAYS) recency[base+w] = ipvrr_pkg::POS_W'(p + 1);
          end
          recency[base+way] = ipvrr_pkg::POS_W'(ins);
        end
      end
      ipvrr_pkg::ACT_HIT: begin
        if (way < WAYS && recency[base+way] < WAYS) begin
          old = recency[base+way];
          tgt = promote_vec[old*4 +: 4];
          if (tgt >= WAYS) tgt = WAYS - 1;
          for (w = 0; w < WAYS; w++) begin
            p = recency[base+w];
            if (tgt < old && p >= tgt && p < old)
              recency[base+w] = ipvrr_pkg::POS_W'(p + 1);
            else if (tgt > old && p > old && p <= tgt)
              recency[base+w] = ipvrr_pkg::POS_W'(p - 1);
          end
          recency[base+way] = ipvrr_pkg::POS_W'(tgt);
        end
      end
      ipvrr_pkg::ACT_VICTIM: begin
        res.pos = recency[base];
        for (w = 1; w < WAYS; w++) begin
          if (recency[base+w] > res.pos) begin
            res.pos = recency[base+w];
            res.way = ipvrr_pkg::WAY_IDX_W'(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  // sender: one item per handshake, random gaps after each item
  always @(negedge clk) begin : drive_in
    request_t req;
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        in_tdata <= {4'b0, req.way, req.set, req.act};
        in_tvalid <= 1'b1;
        in_gap <= draw_gap(in_idle_on);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall != 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (out_idle_on && $urandom_range(0, 3) == 0) out_stall <= draw_gap(1'b1);
    end
  end

  // config tracking, result checking, then prediction of newly accepted items
  always @(posedge clk) begin : monitor
    victim_t want, got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ipvrr_pkg::CFG_PROMOTE_VECTOR) promote_vec = cfg_wdata;
        else insert_pos = cfg_wdata[ipvrr_pkg::INS_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        got.way = out_tdata[3:0];
        got.pos = out_tdata[8:4];
        if (expected_victims.size() == 0) begin
          $display("%0t: unexpected result way %0d pos %0d", $time, got.way, got.pos);
          mismatches++;
        end else begin
          want = expected_victims.pop_front();
          if (got.way !== want.way) begin
            $display("%0t: victim_way expected %0d got %0d", $time, want.way, got.way);
            mismatches++;
          end
          if (got.pos !== want.pos) begin
            $display("%0t: victim_position expected %0d got %0d", $time, want.pos, got.pos);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        update_recency(ipvrr_pkg::action_t'(in_tdata[1:0]), in_tdata[7:2], in_tdata[11:8],
                       want);
        expected_victims.push_back(want);
      end
    end
    in_acc <= in_tvalid && in_tready;
  end

  task automatic write_reg(input ipvrr_pkg::cfg_reg_t idx,
                           input logic [ipvrr_pkg::VEC_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add(input ipvrr_pkg::action_t act, input int set, input int way);
    request_t r;
    r.act = act;
    r.set = ipvrr_pkg::SET_IDX_W'(set);
    r.way = ipvrr_pkg::WAY_IDX_W'(way);
    pending_reqs.push_back(r);
  endtask

  // checked at the rising edge, where the driven inputs are settled
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_tvalid || expected_victims.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly a few neighboring sets so that rows fill up, some spread over all sets
  task automatic queue_random(input int unsigned count);
    request_t r;
    int unsigned k, pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      r.act = (pick < 38) ? ipvrr_pkg::ACT_INSERT : (pick < 72) ? ipvrr_pkg::ACT_HIT :
              (pick < 95) ? ipvrr_pkg::ACT_VICTIM : ipvrr_pkg::ACT_NONE;
      r.set = ($urandom_range(0, 4) == 0) ? ipvrr_pkg::SET_IDX_W'($urandom) :
                                            {focus_hi, 2'($urandom)};
      r.way = ipvrr_pkg::WAY_IDX_W'($urandom);
      pending_reqs.push_back(r);
    end
  endtask

  initial begin : stimulus
    logic [ipvrr_pkg::VEC_W-1:0] vec;
    logic [ipvrr_pkg::INS_W-1:0] ins;
    int ph;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(ipvrr_pkg::CFG_PROMOTE_VECTOR, '0);
    write_reg(ipvrr_pkg::CFG_INSERT_POSITION, ipvrr_pkg::VEC_W'(15));
    add(ipvrr_pkg::ACT_VICTIM, 0, 0);     // all-empty set
    add(ipvrr_pkg::ACT_INSERT, 63, 15);
    add(ipvrr_pkg::ACT_INSERT, 63, 0);    // pushes way 15 off the last slot
    add(ipvrr_pkg::ACT_VICTIM, 63, 0);
    add(ipvrr_pkg::ACT_HIT, 63, 0);
    add(ipvrr_pkg::ACT_HIT, 63, 7);       // hit on an empty way
    add(ipvrr_pkg::ACT_NONE, 63, 15);
    add(ipvrr_pkg::ACT_VICTIM, 63, 9);
    add(ipvrr_pkg::ACT_INSERT, 1, 3);
    add(ipvrr_pkg::ACT_INSERT, 1, 9);
    add(ipvrr_pkg::ACT_HIT, 1, 3);
    wait_idle();

    // every target clamps to the back: hits move backward
    write_reg(ipvrr_pkg::CFG_PROMOTE_VECTOR, '1);
    write_reg(ipvrr_pkg::CFG_INSERT_POSITION, ipvrr_pkg::VEC_W'(0));
    add(ipvrr_pkg::ACT_INSERT, 2, 0);
    add(ipvrr_pkg::ACT_INSERT, 2, 1);
    add(ipvrr_pkg::ACT_INSERT, 2, 2);
    add(ipvrr_pkg::ACT_INSERT, 2, 3);
    add(ipvrr_pkg::ACT_HIT, 2, 3);
    add(ipvrr_pkg::ACT_VICTIM, 2, 0);
    add(ipvrr_pkg::ACT_HIT, 2, 0);
    add(ipvrr_pkg::ACT_VICTIM, 2, 0);
    add(ipvrr_pkg::ACT_INSERT, 2, 15);
    add(ipvrr_pkg::ACT_HIT, 2, 1);
    add(ipvrr_pkg::ACT_VICTIM, 2, 15);
    wait_idle();

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          vec = '0;
          ins = 4'd0;
        end
        1: begin
          vec = '1;
          ins = 4'd15;
        end
        2: begin
          vec = 64'hFEDC_BA98_7654_3210;
          ins = 4'd8;
        end
        default: begin
          vec = {$urandom, $urandom};
          ins = ipvrr_pkg::INS_W'($urandom);
        end
      endcase
      in_idle_on = (ph % 3) != 1;
      out_idle_on = (ph % 3) != 2;
      focus_hi = 4'($urandom);
      write_reg(ipvrr_pkg::CFG_PROMOTE_VECTOR, vec);
      write_reg(ipvrr_pkg::CFG_INSERT_POSITION, ipvrr_pkg::VEC_W'(ins));
      queue_random(125);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_victims.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("timeout at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule
